// ----- src/assert_macros.svh -----
// shared assertion macros for the frame pulse generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/mfpg_pkg.sv -----
package mfpg_pkg;

  localparam int DATA_W    = 16;
  localparam int PERIOD_W  = 16;
  localparam int COUNT_W   = 5;
  localparam int DUR_W     = 15;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BIT_COUNT = 4'd1;

  localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 16'd1000;
  localparam logic [COUNT_W-1:0]  BIT_COUNT_RST    = 5'd9;

  localparam int             FILLER_HEAD_US = 10;
  localparam logic [DUR_W-1:0] FILLER_HEAD  = 15'd10;
  localparam logic [DUR_W-1:0] DUR_MAX      = 15'd32767;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_DATA  = 4'b0100,
    ST_FILL  = 4'b1000
  } state_t;

endpackage

// ----- src/manchester_frame_pulse_generator_top.sv -----
// the start symbol is registered in the start state that follows the accepted frame item
// throughput: a frame of n data bits gives n+2 symbols, one per cycle without stall,
//   the bit shift register and its down counter pace the run; the next frame is
//   taken once the filler sits in the output register
// reset: rst is synchronous, active high; registers return to period 1000 and 9 bits
module manchester_frame_pulse_generator_top #(
  parameter int MAX_DATA_BITS = 16,
  parameter int BIT_TIME_US   = 50
) (
  input  logic                           clk,
  input  logic                           rst,
  // frame input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mfpg_pkg::DATA_W-1:0]    data_bits,
  // symbol output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           first_level,
  output logic [mfpg_pkg::DUR_W-1:0]     first_duration,
  output logic                           second_level,
  output logic [mfpg_pkg::DUR_W-1:0]     second_duration,
  output logic                           filler_underrun,
  output logic                           last_symbol,
  // register write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mfpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfpg_pkg::PERIOD_W-1:0]  cfg_data
);

  // bit halves and the pause after the start pulse
  localparam int HALF_LO_US = BIT_TIME_US / 2;
  localparam int HALF_HI_US = BIT_TIME_US - HALF_LO_US;
  localparam int PAUSE_US   = (BIT_TIME_US + 1) / 2;

  localparam logic [mfpg_pkg::DUR_W-1:0] BIT_DUR   = mfpg_pkg::DUR_W'(BIT_TIME_US);
  localparam logic [mfpg_pkg::DUR_W-1:0] HALF_LO   = mfpg_pkg::DUR_W'(HALF_LO_US);
  localparam logic [mfpg_pkg::DUR_W-1:0] HALF_HI   = mfpg_pkg::DUR_W'(HALF_HI_US);
  localparam logic [mfpg_pkg::DUR_W-1:0] PAUSE_DUR = mfpg_pkg::DUR_W'(PAUSE_US);

  // bit counter and its compare width against the 5-bit register
  localparam int CNT_W = $clog2(MAX_DATA_BITS + 1);
  localparam int CMP_W = (CNT_W > mfpg_pkg::COUNT_W) ? CNT_W : mfpg_pkg::COUNT_W;

  // signed remainder of the frame period, large enough for any deficit
  localparam int REM_W = $clog2((2 ** mfpg_pkg::PERIOD_W) +
                                (MAX_DATA_BITS + 2) * BIT_TIME_US +
                                mfpg_pkg::FILLER_HEAD_US) + 1;
  localparam logic signed [REM_W-1:0] REM_HEAD =
    REM_W'(BIT_TIME_US + PAUSE_US + mfpg_pkg::FILLER_HEAD_US);
  localparam logic signed [REM_W-1:0] REM_BIT  = REM_W'(BIT_TIME_US);
  localparam logic signed [REM_W-1:0] REM_CAP  = REM_W'(mfpg_pkg::DUR_MAX);

  logic [mfpg_pkg::PERIOD_W-1:0] frame_period_us;
  logic [mfpg_pkg::COUNT_W-1:0]  data_bit_count;

  mfpg_pkg::state_t              state;
  logic [mfpg_pkg::DATA_W-1:0]   bit_shift;
  logic [CNT_W-1:0]              bit_cnt;
  logic signed [REM_W-1:0]       rem;

  logic                          accept;
  logic                          advance;
  logic [CNT_W-1:0]              bits_eff;
  logic                          rem_neg;
  logic                          rem_big;
  logic [mfpg_pkg::DUR_W-1:0]    fill_dur;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // one frame at a time: new items wait until the filler is loaded
  assign in_stall = (state != mfpg_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // output register may be (re)loaded when empty or being taken
  assign advance  = !out_valid || !out_stall;

  // clamp the bit count to what the block supports
  always_comb begin
    if (CMP_W'(data_bit_count) > CMP_W'(MAX_DATA_BITS)) begin
      bits_eff = CNT_W'(MAX_DATA_BITS);
    end else begin
      bits_eff = CNT_W'(data_bit_count);
    end
  end

  // filler length from the running remainder, saturated both ways
  always_comb begin
    rem_neg = rem[REM_W-1];
    rem_big = !rem_neg && (rem > REM_CAP);
    if (rem_neg) begin
      fill_dur = '0;
    end else if (rem_big) begin
      fill_dur = mfpg_pkg::DUR_MAX;
    end else begin
      fill_dur = rem[mfpg_pkg::DUR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= mfpg_pkg::ST_IDLE;
      out_valid       <= 1'b0;
      frame_period_us <= mfpg_pkg::FRAME_PERIOD_RST;
      data_bit_count  <= mfpg_pkg::BIT_COUNT_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mfpg_pkg::REG_FRAME_PERIOD:   frame_period_us <= cfg_data;
          mfpg_pkg::REG_DATA_BIT_COUNT: data_bit_count  <= cfg_data[mfpg_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end

      if (advance) begin
        out_valid <= (state != mfpg_pkg::ST_IDLE);
      end

      unique case (state)
        mfpg_pkg::ST_IDLE: begin
          if (accept) begin
            // latch payload, bit count and the fixed part of the period budget
            bit_shift <= data_bits;
            bit_cnt   <= bits_eff;
            rem       <= $signed({{(REM_W - mfpg_pkg::PERIOD_W){1'b0}}, frame_period_us})
                         - REM_HEAD;
            state     <= mfpg_pkg::ST_START;
          end
        end
        mfpg_pkg::ST_START: begin
          if (advance) begin
            first_level     <= 1'b1;
            first_duration  <= BIT_DUR;
            second_level    <= 1'b0;
            second_duration <= PAUSE_DUR;
            filler_underrun <= 1'b0;
            last_symbol     <= 1'b0;
            state <= (bit_cnt == '0) ? mfpg_pkg::ST_FILL : mfpg_pkg::ST_DATA;
          end
        end
        mfpg_pkg::ST_DATA: begin
          if (advance) begin
            // one is low then high, zero is high then low
            first_level     <= !bit_shift[0];
            first_duration  <= HALF_LO;
            second_level    <= bit_shift[0];
            second_duration <= HALF_HI;
            filler_underrun <= 1'b0;
            last_symbol     <= 1'b0;
            // zeros fill from the top, so bits past the payload send zero
            bit_shift <= {1'b0, bit_shift[mfpg_pkg::DATA_W-1:1]};
            bit_cnt   <= bit_cnt - CNT_W'(1);
            rem       <= rem - REM_BIT;
            if (bit_cnt == CNT_W'(1)) begin
              state <= mfpg_pkg::ST_FILL;
            end
          end
        end
        mfpg_pkg::ST_FILL: begin
          if (advance) begin
            first_level     <= 1'b0;
            first_duration  <= mfpg_pkg::FILLER_HEAD;
            second_level    <= 1'b0;
            second_duration <= fill_dur;
            filler_underrun <= rem_neg;
            last_symbol     <= 1'b1;
            state           <= mfpg_pkg::ST_IDLE;
          end
        end
        default: state <= mfpg_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mfpg_checker.sv -----
`include "assert_macros.svh"

module mfpg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           first_level,
  input logic [mfpg_pkg::DUR_W-1:0]     first_duration,
  input logic                           second_level,
  input logic [mfpg_pkg::DUR_W-1:0]     second_duration,
  input logic                           filler_underrun,
  input logic                           last_symbol
);

  // a stalled item stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // once a frame is taken the block is busy with it
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // the closing filler starts with its fixed low head
  `ASSERT_IMPLIES(a_filler_head, clk, rst, out_valid && last_symbol,
                  !first_level && !second_level &&
                  first_duration == mfpg_pkg::FILLER_HEAD)

  // an underrun only marks a clamped filler
  `ASSERT_IMPLIES(a_underrun_filler, clk, rst, out_valid && filler_underrun,
                  last_symbol && second_duration == '0)

endmodule

bind manchester_frame_pulse_generator_top mfpg_checker u_mfpg_checker (.*);

// ----- dv/tb_manchester_frame_pulse_generator_top.sv -----
`timescale 1ns / 1ps

module tb_manchester_frame_pulse_generator_top;

  // block parameters, passed to the instance so the predictor agrees with it
  localparam int MAX_DATA_BITS = 16;
  localparam int BIT_TIME_US   = 50;

  // symbol timing derived from the bit time
  localparam int HALF_LO_US = BIT_TIME_US / 2;
  localparam int HALF_HI_US = BIT_TIME_US - HALF_LO_US;
  localparam int PAUSE_US   = (BIT_TIME_US + 1) / 2;

  // quiet cycles (nothing accepted anywhere) before the run is called hung
  localparam int QUIET_LIMIT = 4000;
  // settle time after the last symbol
  localparam int SETTLE_CYCLES = 8;
  // random frames per random phase
  localparam int PHASE_FRAMES = 28;
  localparam int NUM_PHASES   = 9;

  typedef struct packed {
    logic                       first_level;
    logic [mfpg_pkg::DUR_W-1:0] first_duration;
    logic                       second_level;
    logic [mfpg_pkg::DUR_W-1:0] second_duration;
    logic                       filler_underrun;
    logic                       last_symbol;
  } symbol_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  // frame input channel
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [mfpg_pkg::DATA_W-1:0]    data_bits = '0;
  // symbol output channel
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           first_level;
  logic [mfpg_pkg::DUR_W-1:0]     first_duration;
  logic                           second_level;
  logic [mfpg_pkg::DUR_W-1:0]     second_duration;
  logic                           filler_underrun;
  logic                           last_symbol;
  // register write channel
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mfpg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mfpg_pkg::PERIOD_W-1:0]  cfg_data = '0;

  // mirror of the block's registers, updated on each accepted write
  logic [mfpg_pkg::PERIOD_W-1:0]  period_mirror = mfpg_pkg::FRAME_PERIOD_RST;
  logic [mfpg_pkg::COUNT_W-1:0]   bit_count_mirror = mfpg_pkg::BIT_COUNT_RST;

  // symbols still owed by the block, oldest first
  symbol_t pending_symbols[$];

  // idle rates in percent, set per random phase
  int unsigned in_idle_pct = 18;
  int unsigned out_stall_pct = 18;

  // run statistics
  int error_count = 0;
  int frames_sent = 0;
  int symbols_checked = 0;
  int underrun_frames = 0;
  int saturated_frames = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  manchester_frame_pulse_generator_top #(
    .MAX_DATA_BITS (MAX_DATA_BITS),
    .BIT_TIME_US   (BIT_TIME_US)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_bits       (data_bits),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .first_level     (first_level),
    .first_duration  (first_duration),
    .second_level    (second_level),
    .second_duration (second_duration),
    .filler_underrun (filler_underrun),
    .last_symbol     (last_symbol),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // frame predictor: builds the whole symbol run for one payload
  // ---------------------------------------------------------------------------

  task automatic predict_frame(input logic [mfpg_pkg::DATA_W-1:0] payload);
    int            nbits;
    int            rest;
    logic [31:0]   shreg;
    symbol_t       sym;
    nbits = (int'(bit_count_mirror) > MAX_DATA_BITS) ? MAX_DATA_BITS
                                                     : int'(bit_count_mirror);
    // positions past the payload width shift in zeros
    shreg = {16'h0, payload};
    // start pulse: high for a bit time, then low pause
    sym = '{1'b1, mfpg_pkg::DUR_W'(BIT_TIME_US), 1'b0, mfpg_pkg::DUR_W'(PAUSE_US),
            1'b0, 1'b0};
    pending_symbols.push_back(sym);
    // data symbols, lsb first; a one is low then high
    for (int i = 0; i < nbits; i++) begin
      if (shreg[0])
        sym = '{1'b0, mfpg_pkg::DUR_W'(HALF_LO_US), 1'b1, mfpg_pkg::DUR_W'(HALF_HI_US),
                1'b0, 1'b0};
      else
        sym = '{1'b1, mfpg_pkg::DUR_W'(HALF_LO_US), 1'b0, mfpg_pkg::DUR_W'(HALF_HI_US),
                1'b0, 1'b0};
      pending_symbols.push_back(sym);
      shreg = shreg >> 1;
    end
    // closing filler takes whatever is left of the period
    rest = int'(period_mirror) - (nbits * BIT_TIME_US + BIT_TIME_US + PAUSE_US)
           - mfpg_pkg::FILLER_HEAD_US;
    sym = '{1'b0, mfpg_pkg::FILLER_HEAD, 1'b0, '0, 1'b0, 1'b1};
    if (rest < 0) begin
      // too short a period: clamp to zero and flag it
      sym.filler_underrun = 1'b1;
      underrun_frames++;
    end else if (rest > int'(mfpg_pkg::DUR_MAX)) begin
      // too long: saturate silently
      sym.second_duration = mfpg_pkg::DUR_MAX;
      saturated_frames++;
    end else begin
      sym.second_duration = mfpg_pkg::DUR_W'(rest);
    end
    pending_symbols.push_back(sym);
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offers one frame item; valid stays high on return so a following frame
  // can go out back to back without a drop in the same step
  task automatic send_frame(input logic [mfpg_pkg::DATA_W-1:0] payload);
    // occasional gap of varying length so it lands on every symbol of a run
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_bits <= payload;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    predict_frame(payload);
    frames_sent++;
  endtask

  // random payload with the all-zero and all-one words mixed in
  function automatic logic [mfpg_pkg::DATA_W-1:0] random_payload();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? '1 : '0;
    return mfpg_pkg::DATA_W'($urandom_range(0, 65535));
  endfunction

  // one register write; cfg_valid is left high for back-to-back writes
  task automatic write_reg(input logic [mfpg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mfpg_pkg::PERIOD_W-1:0] wdata);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= wdata;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mfpg_pkg::REG_FRAME_PERIOD:   period_mirror = wdata;
      mfpg_pkg::REG_DATA_BIT_COUNT: bit_count_mirror = wdata[mfpg_pkg::COUNT_W-1:0];
      default: ;  // unmapped index, no effect
    endcase
    reg_writes++;
  endtask

  // drops the frame valid and waits for every owed symbol to come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
  endtask

  // registers are only touched while the block is idle
  task automatic set_config(input logic [mfpg_pkg::PERIOD_W-1:0] period,
                            input logic [mfpg_pkg::PERIOD_W-1:0] count_word);
    wait_drained();
    write_reg(mfpg_pkg::REG_FRAME_PERIOD, period);
    write_reg(mfpg_pkg::REG_DATA_BIT_COUNT, count_word);
    cfg_valid <= 1'b0;
  endtask

  // output stall, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // symbol checker
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    symbol_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_symbols.size() == 0) begin
        $display("%0t ns: symbol with none expected, expected nothing, actual %h",
                 $time, {first_level, first_duration, second_level, second_duration,
                         filler_underrun, last_symbol});
        error_count++;
      end else begin
        want = pending_symbols.pop_front();
        check_field("first_level", want.first_level, first_level);
        check_field("first_duration", want.first_duration, first_duration);
        check_field("second_level", want.second_level, second_level);
        check_field("second_duration", want.second_duration, second_duration);
        check_field("filler_underrun", want.filler_underrun, filler_underrun);
        check_field("last_symbol", want.last_symbol, last_symbol);
        symbols_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: counts cycles where no channel moves anything
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles, %0d symbols still owed",
               $time, QUIET_LIMIT, pending_symbols.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: period 1000 and 9 bits, with the payload extremes
  task automatic test_reset_defaults();
    send_frame(16'h0000);
    send_frame(16'hffff);
    send_frame(16'haaaa);
    send_frame(16'h5555);
  endtask

  // no bits, one bit, full width, and counts past the maximum
  task automatic test_bit_counts();
    set_config(16'd1000, 16'd0);
    send_frame(16'hffff);
    send_frame(16'h1234);
    set_config(16'd1000, 16'd1);
    send_frame(16'h0000);
    send_frame(16'h0001);
    set_config(16'd2000, 16'd16);
    send_frame(16'hffff);
    send_frame(16'h0000);
    send_frame(16'h8001);
    // above the maximum the block must clamp to full width
    set_config(16'd2000, 16'd17);
    send_frame(16'hc3a5);
    set_config(16'd2000, 16'd31);
    send_frame(16'h5a3c);
  endtask

  // filler at zero, just under it, exactly at the saturation edge and past it
  task automatic test_filler_limits();
    set_config(16'd85, 16'd0);     // filler exactly zero, no flag
    send_frame(16'h0001);
    set_config(16'd84, 16'd0);     // one short: underrun
    send_frame(16'h0001);
    set_config(16'd0, 16'd16);     // zero period with full width
    send_frame(16'hffff);
    set_config(16'd32852, 16'd0);  // filler lands on the top of its range
    send_frame(16'h0000);
    set_config(16'd32853, 16'd0);  // one over: saturates
    send_frame(16'h0000);
    set_config(16'd65535, 16'd16); // largest period
    send_frame(16'h7ffe);
  endtask

  // unmapped indexes must be ignored, and the count register keeps 5 bits
  task automatic test_register_writes();
    wait_drained();
    for (int idx = 2; idx < (1 << mfpg_pkg::CFG_IDX_W); idx++)
      write_reg(mfpg_pkg::CFG_IDX_W'(idx), mfpg_pkg::PERIOD_W'($urandom_range(0, 65535)));
    write_reg(mfpg_pkg::REG_DATA_BIT_COUNT, 16'hffe3);
    cfg_valid <= 1'b0;
    send_frame(16'h00f5);
    send_frame(16'hff0a);
  endtask

  // random payloads over a spread of register settings
  task automatic test_random_frames();
    logic [mfpg_pkg::PERIOD_W-1:0] period;
    logic [mfpg_pkg::PERIOD_W-1:0] count_word;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          // long stretch with no idling on either side
          period     = mfpg_pkg::FRAME_PERIOD_RST;
          count_word = 16'(mfpg_pkg::BIT_COUNT_RST);
        end
        1: begin
          period     = 16'hffff;
          count_word = 16'(MAX_DATA_BITS);
        end
        2: begin
          // short periods, mostly underrun
          period     = 16'($urandom_range(0, 900));
          count_word = 16'($urandom_range(0, MAX_DATA_BITS));
        end
        3: begin
          period     = 16'd0;
          count_word = 16'd0;
        end
        4: begin
          // full-width register words, count masked by the block
          period     = 16'($urandom_range(0, 65535));
          count_word = 16'($urandom_range(0, 65535));
        end
        5: begin
          period     = 16'($urandom_range(0, 65535));
          count_word = 16'($urandom_range(MAX_DATA_BITS + 1, 31));
        end
        default: begin
          period     = 16'($urandom_range(800, 2000));
          count_word = 16'($urandom_range(0, MAX_DATA_BITS));
        end
      endcase
      set_config(period, count_word);
      in_idle_pct   = (phase == 0) ? 0 : 18;
      out_stall_pct = (phase == 0) ? 0 : 18;
      repeat (PHASE_FRAMES) send_frame(random_payload());
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    // synchronous reset held at the start, then released
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_bit_counts();
    test_filler_limits();
    test_register_writes();
    test_random_frames();

    // let the last runs come out, then watch for stray symbols
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d frames, %0d symbols checked, %0d register writes",
             frames_sent, symbols_checked, reg_writes);
    $display("fillers clamped to zero: %0d, fillers saturated: %0d",
             underrun_frames, saturated_frames);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
